// ----- rtl/csmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock set-mode controller package
// Shared types and constants for the front, queue and back modules.
// ----------------------------------------------------------------------------
package csmc_pkg;

  localparam int PRESS_TIMER_BITS = 16;
  localparam int THR_BITS = 16;
  localparam int CMP_W = (PRESS_TIMER_BITS > THR_BITS) ? PRESS_TIMER_BITS : THR_BITS;
  localparam int NUM_BUTTONS = 3;
  localparam logic [THR_BITS-1:0] LONG_PRESS_RESET = 16'd2000;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [4:0] {
    MODE_TIME      = 5'd0,
    MODE_HOUR_ADJ  = 5'd1,
    MODE_MIN_ADJ   = 5'd2,
    MODE_SEC_ADJ   = 5'd3,
    MODE_DATE      = 5'd4,
    MODE_DAY_ADJ   = 5'd5,
    MODE_MONTH_ADJ = 5'd6,
    MODE_YEAR      = 5'd7,
    MODE_YEAR_ADJ  = 5'd8,
    MODE_TEST0     = 5'd9,
    MODE_TEST1     = 5'd10,
    MODE_TEST2     = 5'd11,
    MODE_TEST3     = 5'd12,
    MODE_TEST4     = 5'd13,
    MODE_TEST5     = 5'd14,
    MODE_BRIGHT    = 5'd15,
    MODE_INVALID   = 5'd16
  } mode_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } tm_fields_t;

  typedef struct packed {
    logic                   is_load;
    logic [NUM_BUTTONS-1:0] ev_short;
    logic [NUM_BUTTONS-1:0] ev_long;
    tm_fields_t             tm;
  } cmd_t;

endpackage

// ----- rtl/clock_set_mode_controller.sv -----
// ----------------------------------------------------------------------------
// Clock set-mode controller
// Three-button set-mode controller with press timers, display modes,
// brightness and a held copy of the clock-chip time.
//
//   Channel   Direction  Handshake              Payload
//   in_*      input      in_valid / in_ready    req_type, buttons, time load
//   out_*     output     out_valid / out_ready  mode, brightness, time, mask
//   cfg_*     input      cfg_we                 long-press threshold
//
// One item per cycle is sustained while the output is ready. A transfer in
// enters the command queue, its result is then registered in the back end
// and transfers out from there.
// The front end classifies button events, a two-entry queue decouples it
// from the back end, which applies them to the mode and held time.
// Reset is synchronous and active low.
// A stalled output holds the back end; the front end keeps accepting until
// the queue is full.
// ----------------------------------------------------------------------------
module clock_set_mode_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [2:0]  in_buttons,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [7:0]  in_year_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_mode,
  output logic [3:0]  out_brightness,
  output logic [4:0]  out_hour_now,
  output logic [5:0]  out_minute_now,
  output logic [5:0]  out_second_now,
  output logic [4:0]  out_day_now,
  output logic [3:0]  out_month_now,
  output logic [7:0]  out_year_now,
  output logic [5:0]  out_write_mask
);
  import csmc_pkg::*;

  tm_fields_t in_tm;
  cmd_t       push_data, pop_data;
  logic       push_valid, push_ready, pop_valid, pop_ready;

  always_comb begin
    in_tm.hour   = in_hour;
    in_tm.minute = in_minute;
    in_tm.second = in_second;
    in_tm.day    = in_day;
    in_tm.month  = in_month;
    in_tm.year   = in_year_offset;
  end

  csmc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_buttons  (in_buttons),
    .in_tm       (in_tm),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  csmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  csmc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mode       (out_mode),
    .out_brightness (out_brightness),
    .out_hour_now   (out_hour_now),
    .out_minute_now (out_minute_now),
    .out_second_now (out_second_now),
    .out_day_now    (out_day_now),
    .out_month_now  (out_month_now),
    .out_year_now   (out_year_now),
    .out_write_mask (out_write_mask)
  );

endmodule

// ----- rtl/csmc_front.sv -----
// ----------------------------------------------------------------------------
// Clock set-mode controller front end
// Tracks button levels and press timers and classifies each tick into
// short and long press events before handing it to the command queue.
// ----------------------------------------------------------------------------
module csmc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [2:0]                in_buttons,
  input  csmc_pkg::tm_fields_t      in_tm,
  output logic                      push_valid,
  input  logic                      push_ready,
  output csmc_pkg::cmd_t            push_data
);
  import csmc_pkg::*;

  logic [THR_BITS-1:0]         thr_r;
  logic [NUM_BUTTONS-1:0]      prev_r, prev_nxt;
  logic [NUM_BUTTONS-1:0]      lflag_r, lflag_nxt;
  logic [PRESS_TIMER_BITS-1:0] timer_r   [NUM_BUTTONS];
  logic [PRESS_TIMER_BITS-1:0] timer_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]      ev_short, ev_long;
  logic                        accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    logic [PRESS_TIMER_BITS-1:0] t;
    logic [CMP_W-1:0]            t_ext;
    logic [CMP_W-1:0]            thr_ext;
    logic                        now;
    logic                        was;
    thr_ext   = CMP_W'(thr_r);
    prev_nxt  = prev_r;
    lflag_nxt = lflag_r;
    ev_short  = '0;
    ev_long   = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      timer_nxt[i] = timer_r[i];
      now   = in_buttons[i];
      was   = prev_r[i];
      t     = (timer_r[i] == '1) ? timer_r[i] : timer_r[i] + 1'b1;
      t_ext = CMP_W'(t);
      if (in_req_type == REQ_TICK) begin
        if (now && !was) begin
          timer_nxt[i] = '0;
        end else begin
          timer_nxt[i] = t;
          if (!now && was) begin
            if (t_ext < thr_ext) begin
              ev_short[i] = 1'b1;
            end else begin
              lflag_nxt[i] = 1'b0;
            end
          end else if (now && was && !lflag_r[i] && (t_ext > thr_ext)) begin
            lflag_nxt[i] = 1'b1;
            ev_long[i]   = 1'b1;
          end
        end
      end
    end
    if (in_req_type == REQ_TICK) begin
      prev_nxt = in_buttons;
    end
  end

  always_comb begin
    push_data          = '0;
    push_data.is_load  = (in_req_type == REQ_LOAD);
    push_data.ev_short = ev_short;
    push_data.ev_long  = ev_long;
    push_data.tm       = in_tm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      lflag_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        timer_r[i] <= '0;
      end
    end else if (accept) begin
      prev_r  <= prev_nxt;
      lflag_r <= lflag_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        timer_r[i] <= timer_nxt[i];
      end
    end
  end

endmodule

// ----- rtl/csmc_queue.sv -----
// ----------------------------------------------------------------------------
// Clock set-mode controller command queue
// Two-entry queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module csmc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  csmc_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output csmc_pkg::cmd_t pop_data
);
  import csmc_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

// ----- rtl/csmc_back.sv -----
// ----------------------------------------------------------------------------
// Clock set-mode controller back end
// Applies classified commands to the mode, brightness and held time, and
// holds the result until the output transfer completes.
// ----------------------------------------------------------------------------
module csmc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  csmc_pkg::cmd_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [4:0]     out_mode,
  output logic [3:0]     out_brightness,
  output logic [4:0]     out_hour_now,
  output logic [5:0]     out_minute_now,
  output logic [5:0]     out_second_now,
  output logic [4:0]     out_day_now,
  output logic [3:0]     out_month_now,
  output logic [7:0]     out_year_now,
  output logic [5:0]     out_write_mask
);
  import csmc_pkg::*;

  typedef struct packed {
    logic [3:0] bright;
    tm_fields_t tm;
  } hold_t;

  typedef struct packed {
    hold_t      h;
    logic [5:0] mask;
  } step_res_t;

  mode_t      mode_r, mode_nxt, mode_b0;
  hold_t      hold_r, hold_nxt;
  logic [5:0] mask_r, mask_nxt;
  logic       out_valid_r;
  logic       pop;
  step_res_t  res_up, res_dn;

  function automatic mode_t short_next(mode_t m);
    mode_t r;
    unique case (m)
      MODE_TIME:      r = MODE_DATE;
      MODE_HOUR_ADJ:  r = MODE_MIN_ADJ;
      MODE_MIN_ADJ:   r = MODE_SEC_ADJ;
      MODE_SEC_ADJ:   r = MODE_HOUR_ADJ;
      MODE_DATE:      r = MODE_YEAR;
      MODE_DAY_ADJ:   r = MODE_MONTH_ADJ;
      MODE_MONTH_ADJ: r = MODE_DAY_ADJ;
      MODE_YEAR:      r = MODE_TEST0;
      MODE_YEAR_ADJ:  r = MODE_YEAR_ADJ;
      MODE_TEST0:     r = MODE_BRIGHT;
      MODE_TEST1:     r = MODE_TEST2;
      MODE_TEST2:     r = MODE_TEST3;
      MODE_TEST3:     r = MODE_TEST4;
      MODE_TEST4:     r = MODE_TEST5;
      MODE_TEST5:     r = MODE_TEST1;
      MODE_BRIGHT:    r = MODE_TIME;
      default:        r = MODE_INVALID;
    endcase
    return r;
  endfunction

  function automatic mode_t long_next(mode_t m);
    mode_t r;
    unique case (m) inside
      MODE_TIME:                                  r = MODE_HOUR_ADJ;
      MODE_HOUR_ADJ, MODE_MIN_ADJ, MODE_SEC_ADJ:  r = MODE_TIME;
      MODE_DATE:                                  r = MODE_DAY_ADJ;
      MODE_DAY_ADJ, MODE_MONTH_ADJ:               r = MODE_DATE;
      MODE_YEAR:                                  r = MODE_YEAR_ADJ;
      MODE_YEAR_ADJ:                              r = MODE_YEAR;
      MODE_TEST0:                                 r = MODE_TEST1;
      MODE_TEST1, MODE_TEST2, MODE_TEST3,
      MODE_TEST4, MODE_TEST5:                     r = MODE_TEST0;
      MODE_BRIGHT:                                r = MODE_INVALID;
      default:                                    r = MODE_BRIGHT;
    endcase
    return r;
  endfunction

  function automatic step_res_t step(mode_t m, hold_t h, logic down);
    step_res_t  r;
    logic [6:0] t7;
    logic [5:0] t6;
    logic [4:0] t5;
    r.h    = h;
    r.mask = 6'd0;
    unique case (m)
      MODE_HOUR_ADJ: begin
        t7 = down ? 7'(h.tm.hour) + 7'd23 : 7'(h.tm.hour) + 7'd25;
        if (t7 >= 7'd24) t7 = t7 - 7'd24;
        if (t7 >= 7'd24) t7 = t7 - 7'd24;
        r.h.tm.hour = 5'(t7);
        r.mask      = 6'b000001;
      end
      MODE_MIN_ADJ: begin
        t7 = down ? 7'(h.tm.minute) + 7'd59 : 7'(h.tm.minute) + 7'd61;
        if (t7 >= 7'd60) t7 = t7 - 7'd60;
        if (t7 >= 7'd60) t7 = t7 - 7'd60;
        r.h.tm.minute = 6'(t7);
        r.h.tm.second = 6'd0;
        r.mask        = 6'b000110;
      end
      MODE_SEC_ADJ: begin
        t7 = down ? 7'(h.tm.second) + 7'd59 : 7'(h.tm.second) + 7'd61;
        if (t7 >= 7'd60) t7 = t7 - 7'd60;
        if (t7 >= 7'd60) t7 = t7 - 7'd60;
        r.h.tm.second = 6'(t7);
        r.mask        = 6'b000100;
      end
      MODE_DAY_ADJ: begin
        if (down) begin
          if (h.tm.day == 5'd0) begin
            r.h.tm.day = 5'd30;
          end else if (h.tm.day == 5'd1) begin
            r.h.tm.day = 5'd31;
          end else begin
            r.h.tm.day = h.tm.day - 5'd1;
          end
        end else begin
          t6 = 6'(h.tm.day) + 6'd1;
          if (t6 > 6'd31) t6 = t6 - 6'd31;
          r.h.tm.day = 5'(t6);
        end
        r.mask = 6'b001000;
      end
      MODE_MONTH_ADJ: begin
        if (down) begin
          if (h.tm.month == 4'd0) begin
            r.h.tm.month = 4'd11;
          end else begin
            t5 = 5'(h.tm.month) - 5'd1;
            if (t5 == 5'd0) begin
              t5 = 5'd12;
            end else if (t5 > 5'd12) begin
              t5 = t5 - 5'd12;
            end
            r.h.tm.month = 4'(t5);
          end
        end else begin
          t5 = 5'(h.tm.month) + 5'd1;
          if (t5 > 5'd12) t5 = t5 - 5'd12;
          r.h.tm.month = 4'(t5);
        end
        r.mask = 6'b010000;
      end
      MODE_YEAR_ADJ: begin
        r.h.tm.year = down ? h.tm.year - 8'd1 : h.tm.year + 8'd1;
        r.mask      = 6'b100000;
      end
      MODE_BRIGHT: begin
        if (down) begin
          if (h.bright != 4'd0) r.h.bright = h.bright - 4'd1;
        end else begin
          if (h.bright != 4'd15) r.h.bright = h.bright + 4'd1;
        end
      end
      default: begin
        r.mask = 6'd0;
      end
    endcase
    return r;
  endfunction

  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    mode_b0 = mode_r;
    if (pop_data.ev_short[0]) begin
      mode_b0 = short_next(mode_r);
    end else if (pop_data.ev_long[0]) begin
      mode_b0 = long_next(mode_r);
    end
  end

  always_comb begin
    res_up = step(mode_b0, hold_r, 1'b0);
    if (!pop_data.ev_short[1]) begin
      res_up.h    = hold_r;
      res_up.mask = 6'd0;
    end
    res_dn = step(mode_b0, res_up.h, 1'b1);
    if (!pop_data.ev_short[2]) begin
      res_dn.h    = res_up.h;
      res_dn.mask = 6'd0;
    end
  end

  always_comb begin
    if (pop_data.is_load) begin
      mode_nxt    = mode_r;
      hold_nxt    = hold_r;
      hold_nxt.tm = pop_data.tm;
      mask_nxt    = 6'd0;
    end else begin
      mode_nxt = mode_b0;
      hold_nxt = res_dn.h;
      mask_nxt = res_up.mask | res_dn.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= MODE_TIME;
      hold_r      <= '{bright: 4'd0,
                       tm: '{hour: 5'd0, minute: 6'd0, second: 6'd0,
                             day: 5'd1, month: 4'd1, year: 8'd0}};
      mask_r      <= 6'd0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        hold_r      <= hold_nxt;
        mask_r      <= mask_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mode       = mode_r;
  assign out_brightness = hold_r.bright;
  assign out_hour_now   = hold_r.tm.hour;
  assign out_minute_now = hold_r.tm.minute;
  assign out_second_now = hold_r.tm.second;
  assign out_day_now    = hold_r.tm.day;
  assign out_month_now  = hold_r.tm.month;
  assign out_year_now   = hold_r.tm.year;
  assign out_write_mask = mask_r;

endmodule

// ----- sim/clock_set_mode_controller_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clock set-mode controller testbench
// Sends button ticks and time loads through the input channel and tracks the
// expected mode, brightness, held time and write mask of every item. A short
// directed sequence comes first. Random button presses, ticks and time loads
// follow under several long-press thresholds and three idling patterns.
// ----------------------------------------------------------------------------
module clock_set_mode_controller_test;
  import csmc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TIMER_MAX = (1 << PRESS_TIMER_BITS) - 1;
  localparam int BTN_MODE = 0;
  localparam int BTN_UP = 1;
  localparam int BTN_DOWN = 2;
  localparam int SEGMENT_ITEMS = 200;
  localparam int MODE_NUM [17] = '{100, 101, 102, 103, 200, 201, 202, 300, 301,
                                   400, 401, 402, 403, 404, 405, 500, 501};
  localparam int GROUP_TOP [5] = '{103, 202, 301, 405, 500};
  localparam int THRESHOLD_PLAN [9] = '{1, 3, 65535, 2, 7, 2000, 4, 10, 5};
  localparam logic [5:0] WM_HOUR   = 6'b000001;
  localparam logic [5:0] WM_MINUTE = 6'b000010;
  localparam logic [5:0] WM_SECOND = 6'b000100;
  localparam logic [5:0] WM_DAY    = 6'b001000;
  localparam logic [5:0] WM_MONTH  = 6'b010000;
  localparam logic [5:0] WM_YEAR   = 6'b100000;

  typedef struct packed {
    logic       req_type;
    logic [2:0] buttons;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } panel_item_t;

  typedef struct packed {
    logic [4:0] mode;
    logic [3:0] brightness;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    logic [5:0] write_mask;
  } panel_view_t;

  class panel_checker;
    mode_t       mode = MODE_TIME;
    int          brightness = 0;
    int          hour = 0;
    int          minute = 0;
    int          second = 0;
    int          day = 1;
    int          month = 1;
    int          year = 0;
    logic [2:0]  prev_buttons = 3'b000;
    int          press_ticks [NUM_BUTTONS] = '{default: 0};
    bit          long_held [NUM_BUTTONS] = '{default: 1'b0};
    int          threshold = int'(LONG_PRESS_RESET);
    panel_view_t pending_views [$];
    int          errors = 0;
    int          checked = 0;

    function void set_threshold(logic [15:0] value);
      threshold = int'(value);
    endfunction

    function int pending();
      return pending_views.size();
    endfunction

    function int mode_number();
      int c;
      c = (mode > MODE_INVALID) ? int'(MODE_INVALID) : int'(mode);
      return MODE_NUM[c];
    endfunction

    function void go_mode(int n);
      int g;
      int target;
      g = n / 100;
      if (g < 1 || g > 5) return;
      target = (n <= GROUP_TOP[g-1]) ? n : g * 100 + 1;
      for (int c = 0; c < 17; c++) begin
        if (MODE_NUM[c] == target) mode = mode_t'(c);
      end
    endfunction

    function int wrap_one_based(int v, int d, int span);
      int t;
      t = v + d;
      if (t >= 0 && t % span == 0) return span;
      return (span + t) % span;
    endfunction

    function logic [5:0] step_field(int d);
      int b;
      case (mode)
        MODE_HOUR_ADJ: begin
          hour = (24 + hour + d) % 24;
          return WM_HOUR;
        end
        MODE_MIN_ADJ: begin
          second = 0;
          minute = (60 + minute + d) % 60;
          return WM_MINUTE | WM_SECOND;
        end
        MODE_SEC_ADJ: begin
          second = (60 + second + d) % 60;
          return WM_SECOND;
        end
        MODE_DAY_ADJ: begin
          day = wrap_one_based(day, d, 31);
          return WM_DAY;
        end
        MODE_MONTH_ADJ: begin
          month = wrap_one_based(month, d, 12);
          return WM_MONTH;
        end
        MODE_YEAR_ADJ: begin
          year = (year + d + 256) & 255;
          return WM_YEAR;
        end
        MODE_BRIGHT: begin
          b = brightness + d;
          if (b > 15) b = 15;
          if (b < 0) b = 0;
          brightness = b;
          return 6'b000000;
        end
        default: return 6'b000000;
      endcase
    endfunction

    function void accept_item(panel_item_t item);
      panel_view_t view;
      logic [5:0]  mask;
      int          n;
      int          sub;
      bit          pressed_now;
      bit          pressed_prev;
      mask = 6'b000000;
      if (item.req_type == REQ_LOAD) begin
        hour = int'(item.hour);
        minute = int'(item.minute);
        second = int'(item.second);
        day = int'(item.day);
        month = int'(item.month);
        year = int'(item.year);
      end else begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          pressed_now = item.buttons[i];
          pressed_prev = prev_buttons[i];
          n = mode_number();
          sub = n % 100;
          if (pressed_now && !pressed_prev) begin
            press_ticks[i] = 0;
            continue;
          end
          if (press_ticks[i] < TIMER_MAX) press_ticks[i]++;
          if (!pressed_now && pressed_prev) begin
            if (press_ticks[i] < threshold) begin
              if (i == BTN_MODE) go_mode(sub == 0 ? (n % 500) + 100 : n + 1);
              else mask |= step_field(i == BTN_UP ? 1 : -1);
            end else begin
              long_held[i] = 1'b0;
            end
          end else if (pressed_now && pressed_prev && !long_held[i] &&
                       press_ticks[i] > threshold) begin
            long_held[i] = 1'b1;
            if (i == BTN_MODE) go_mode(sub == 0 ? n + 1 : (n / 100) * 100);
          end
        end
        prev_buttons = item.buttons;
      end
      view.mode = mode;
      view.brightness = 4'(brightness);
      view.hour = 5'(hour);
      view.minute = 6'(minute);
      view.second = 6'(second);
      view.day = 5'(day);
      view.month = 4'(month);
      view.year = 8'(year);
      view.write_mask = mask;
      pending_views.push_back(view);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                  checked, name, got, want));
    endtask

    task check_view(panel_view_t got);
      panel_view_t want;
      if (pending_views.size() == 0) begin
        report_mismatch($sformatf("result after %0d arrived with nothing expected",
                                  checked));
        return;
      end
      want = pending_views.pop_front();
      check_field("mode", int'(got.mode), int'(want.mode));
      check_field("brightness", int'(got.brightness), int'(want.brightness));
      check_field("hour", int'(got.hour), int'(want.hour));
      check_field("minute", int'(got.minute), int'(want.minute));
      check_field("second", int'(got.second), int'(want.second));
      check_field("day", int'(got.day), int'(want.day));
      check_field("month", int'(got.month), int'(want.month));
      check_field("year", int'(got.year), int'(want.year));
      check_field("write_mask", int'(got.write_mask), int'(want.write_mask));
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [2:0]  in_buttons = 3'd0;
  logic [4:0]  in_hour = 5'd0;
  logic [5:0]  in_minute = 6'd0;
  logic [5:0]  in_second = 6'd0;
  logic [4:0]  in_day = 5'd0;
  logic [3:0]  in_month = 4'd0;
  logic [7:0]  in_year_offset = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_mode;
  logic [3:0]  out_brightness;
  logic [4:0]  out_hour_now;
  logic [5:0]  out_minute_now;
  logic [5:0]  out_second_now;
  logic [4:0]  out_day_now;
  logic [3:0]  out_month_now;
  logic [7:0]  out_year_now;
  logic [5:0]  out_write_mask;

  panel_checker tracker;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           items_sent = 0;
  int           cur_threshold = int'(LONG_PRESS_RESET);
  int           stall_cycles = 0;

  clock_set_mode_controller u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_buttons     (in_buttons),
    .in_hour        (in_hour),
    .in_minute      (in_minute),
    .in_second      (in_second),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year_offset (in_year_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mode       (out_mode),
    .out_brightness (out_brightness),
    .out_hour_now   (out_hour_now),
    .out_minute_now (out_minute_now),
    .out_second_now (out_second_now),
    .out_day_now    (out_day_now),
    .out_month_now  (out_month_now),
    .out_year_now   (out_year_now),
    .out_write_mask (out_write_mask)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (in_valid && in_ready)
      tracker.accept_item({in_req_type, in_buttons, in_hour, in_minute, in_second,
                           in_day, in_month, in_year_offset});
    if (out_valid && out_ready)
      tracker.check_view({out_mode, out_brightness, out_hour_now, out_minute_now,
                          out_second_now, out_day_now, out_month_now, out_year_now,
                          out_write_mask});
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_item(panel_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = item.req_type;
    in_buttons = item.buttons;
    in_hour = item.hour;
    in_minute = item.minute;
    in_second = item.second;
    in_day = item.day;
    in_month = item.month;
    in_year_offset = item.year;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic tick(logic [2:0] levels);
    panel_item_t item;
    item.req_type = REQ_TICK;
    item.buttons = levels;
    {item.hour, item.minute, item.second, item.day} = 22'($urandom);
    {item.month, item.year} = 12'($urandom);
    send_item(item);
  endtask

  task automatic load_time(logic [4:0] h, logic [5:0] mi, logic [5:0] s,
                           logic [4:0] d, logic [3:0] mo, logic [7:0] y);
    panel_item_t item;
    item.req_type = REQ_LOAD;
    item.buttons = 3'($urandom);
    item.hour = h;
    item.minute = mi;
    item.second = s;
    item.day = d;
    item.month = mo;
    item.year = y;
    send_item(item);
  endtask

  task automatic press_button(int b, int holds, logic [2:0] others);
    logic [2:0] held;
    held = others | (3'b001 << b);
    tick(held);
    repeat (holds) tick(held);
    tick(others & ~(3'b001 << b));
  endtask

  task automatic write_threshold(logic [15:0] value);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_threshold(value);
    cur_threshold = int'(value);
  endtask

  task automatic run_segment(int target);
    int         start;
    int         r;
    int         b;
    int         holds;
    logic [2:0] others;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        if ($urandom_range(0, 1))
          load_time(5'($urandom), 6'($urandom), 6'($urandom), 5'($urandom),
                    4'($urandom), 8'($urandom));
        else
          load_time(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                    6'($urandom_range(0, 59)), 5'($urandom_range(1, 31)),
                    4'($urandom_range(1, 12)), 8'($urandom_range(0, 255)));
      end else if (r < 16) begin
        repeat ($urandom_range(1, 4)) tick(3'($urandom_range(0, 7)));
      end else begin
        r = $urandom_range(0, 9);
        b = (r < 4) ? BTN_MODE : (r < 7) ? BTN_UP : BTN_DOWN;
        others = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
        if (cur_threshold > 12) holds = $urandom_range(0, 5);
        else if ($urandom_range(0, 2) == 0) holds = cur_threshold + 1 + $urandom_range(0, 2);
        else holds = $urandom_range(0, cur_threshold + 1);
        press_button(b, holds, others);
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 79;
    load_time(5'd31, 6'd63, 6'd63, 5'd31, 4'd15, 8'd255);
    load_time(5'd0, 6'd0, 6'd0, 5'd0, 4'd0, 8'd0);
    press_button(BTN_MODE, 0, 3'b000);
    write_threshold(16'd2);
    press_button(BTN_MODE, 3, 3'b000);
    press_button(BTN_UP, 0, 3'b000);
    press_button(BTN_DOWN, 0, 3'b000);
    load_time(5'd23, 6'd59, 6'd59, 5'd31, 4'd12, 8'd255);
    // All three buttons released together: the mode step of button 0 applies
    // to buttons 1 and 2 in the same transfer.
    tick(3'b111);
    tick(3'b000);
    press_button(BTN_UP, 1, 3'b000);
    press_button(BTN_MODE, 3, 3'b000);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 38 : (p == 1) ? 79 : 0;
      recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 38 : 0;
      for (int s = 0; s < 3; s++) begin
        write_threshold(16'(THRESHOLD_PLAN[p * 3 + s]));
        run_segment(SEGMENT_ITEMS);
      end
    end

    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
